FILE: rtl/msf_pkg.sv
`default_nettype none
package msf_pkg;

  localparam int MAX_PRIMES   = 128;
  localparam int MASK_ENTRIES = 512;
  localparam int SLOT_W       = 7;
  localparam int RES_W        = 9;
  localparam int PRIME_W      = 9;
  localparam int COUNT_W      = 8;
  localparam int MASK_AW      = SLOT_W + RES_W;

  localparam logic [2:0] CMD_PRIME    = 3'd0;
  localparam logic [2:0] CMD_Z_ORDER  = 3'd1;
  localparam logic [2:0] CMD_RHO_ORD  = 3'd2;
  localparam logic [2:0] CMD_Z_MASK   = 3'd3;
  localparam logic [2:0] CMD_RHO_MASK = 3'd4;
  localparam logic [2:0] CMD_QUERY    = 3'd5;

  typedef struct packed {
    logic [2:0]         command;
    logic [SLOT_W-1:0]  slot;
    logic [RES_W-1:0]   residue;
    logic [8:0]         load_value;
    logic signed [31:0] numerator;
    logic [30:0]        denominator;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] z_depth;
    logic               z_survives;
    logic [COUNT_W-1:0] rho_depth;
    logic               rho_survives;
  } out_t;

  typedef struct packed {
    logic               start;
    logic [31:0]        a_abs;
    logic               a_neg;
    logic [30:0]        b;
    logic [PRIME_W-1:0] p;
  } mod_req_t;

  typedef struct packed {
    logic               done;
    logic [PRIME_W-1:0] idx;
  } mod_res_t;

endpackage
`default_nettype wire

FILE: rtl/msf_ram.sv
`default_nettype none
module msf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/msf_modunit.sv
`default_nettype none
module msf_modunit import msf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mod_req_t req,
  output mod_res_t      res
);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_RED  = 3'd1;
  localparam logic [2:0] M_POW  = 3'd2;
  localparam logic [2:0] M_FIN  = 3'd3;

  logic [2:0]         state;
  logic [4:0]         cnt;
  logic [3:0]         k;
  logic [3:0]         eb;
  logic [31:0]        a_sh;
  logic [31:0]        b_sh;
  logic               neg;
  logic [PRIME_W-1:0] p;
  logic [PRIME_W-1:0] ra;
  logic [PRIME_W-1:0] rb;
  logic [PRIME_W-1:0] x;
  logic [PRIME_W-1:0] r;
  logic [PRIME_W-1:0] e;
  logic [PRIME_W-1:0] acc1;
  logic [PRIME_W-1:0] acc2;
  logic [PRIME_W-1:0] ra_next;
  logic [PRIME_W-1:0] rb_next;
  logic [PRIME_W-1:0] acc1_next;
  logic [PRIME_W-1:0] acc2_next;
  logic [PRIME_W-1:0] am;

  function automatic logic [PRIME_W-1:0] reduce(input logic [PRIME_W+1:0] v,
                                                input logic [PRIME_W-1:0] m);
    logic [PRIME_W+1:0] m1;
    logic [PRIME_W+1:0] m2;
    logic [PRIME_W+1:0] o;
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    if (v >= m2) begin
      o = v - m2;
    end else if (v >= m1) begin
      o = v - m1;
    end else begin
      o = v;
    end
    return o[PRIME_W-1:0];
  endfunction

  always_comb begin
    ra_next   = reduce({1'b0, ra, a_sh[31]}, p);
    rb_next   = reduce({1'b0, rb, b_sh[31]}, p);
    acc1_next = reduce({1'b0, acc1, 1'b0} + {2'b00, (x[k[3:0]] ? r : '0)}, p);
    acc2_next = reduce({1'b0, acc2, 1'b0} + {2'b00, (x[k[3:0]] ? x : '0)}, p);
    am        = (neg && ra_next != '0) ? p - ra_next : ra_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= M_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (req.start) begin
            p    <= req.p;
            neg  <= req.a_neg;
            a_sh <= req.a_abs;
            b_sh <= {1'b0, req.b};
            ra   <= '0;
            rb   <= '0;
            cnt  <= '0;
            if (req.p < PRIME_W'(2)) begin
              res.idx  <= req.p;
              res.done <= 1'b1;
            end else begin
              state <= M_RED;
            end
          end
        end
        M_RED: begin
          ra   <= ra_next;
          rb   <= rb_next;
          a_sh <= {a_sh[30:0], 1'b0};
          b_sh <= {b_sh[30:0], 1'b0};
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            ra <= am;
            if (rb_next == '0) begin
              res.idx  <= p;
              res.done <= 1'b1;
              state    <= M_IDLE;
            end else begin
              x     <= rb_next;
              r     <= PRIME_W'(1);
              e     <= p - PRIME_W'(2);
              eb    <= '0;
              k     <= 4'(PRIME_W - 1);
              acc1  <= '0;
              acc2  <= '0;
              state <= M_POW;
            end
          end
        end
        M_POW: begin
          acc1 <= acc1_next;
          acc2 <= acc2_next;
          k    <= k - 4'd1;
          if (k == 4'd0) begin
            if (e[0]) begin
              r <= acc1_next;
            end
            x    <= acc2_next;
            e    <= e >> 1;
            eb   <= eb + 4'd1;
            k    <= 4'(PRIME_W - 1);
            acc1 <= '0;
            acc2 <= '0;
            if (eb == 4'(PRIME_W - 1)) begin
              x     <= ra;
              state <= M_FIN;
            end
          end
        end
        M_FIN: begin
          acc1 <= acc1_next;
          acc2 <= acc2_next;
          k    <= k - 4'd1;
          if (k == 4'd0) begin
            res.idx  <= acc1_next;
            res.done <= 1'b1;
            state    <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/modular_residue_sieve_filter.sv
`default_nettype none
// Residue sieve over up to 128 loaded primes. Table and mask writes take one
// beat each and finish in the cycle they are accepted. A query walks the z
// order, then the rho order, stopping each walk at the first prime whose
// mask bit is clear. Each prime visited passes through the order read, the
// prime read, the start of the shared modular unit, bit-serial reduction of
// a and b, square-and-multiply over nine exponent bits with one bit-serial
// product step per cycle, the final product, the hand-back of the index and
// the mask read. A denominator divisible by the prime skips both the
// square-and-multiply and the final product, and a prime below two also
// skips the reduction. No input beat is taken while a query is in progress;
// a finished result waits in the output register while the next beat is
// taken. Memories need no clearing after reset.
module modular_residue_sieve_filter import msf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_t                in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_t                    out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [COUNT_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ORD   = 3'd1;
  localparam logic [2:0] S_PRM   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_MSK   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]         state;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] pos;
  logic [COUNT_W-1:0] z_depth;
  logic               search;
  logic [31:0]        a_abs;
  logic               a_neg;
  logic [30:0]        b_val;
  logic               acc;
  logic               finish;

  logic [SLOT_W-1:0]  z_ord_rd;
  logic [SLOT_W-1:0]  rho_ord_rd;
  logic [SLOT_W-1:0]  ord_rd;
  logic [PRIME_W-1:0] prime_rd;
  logic               z_mask_rd;
  logic               rho_mask_rd;
  logic               mask_rd;
  logic [MASK_AW-1:0] mask_waddr;
  logic [MASK_AW-1:0] mask_raddr;

  mod_req_t mreq;
  mod_res_t mres;

  assign in_ready   = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign acc        = in_valid && in_ready;
  assign ord_rd     = search ? rho_ord_rd : z_ord_rd;
  assign mask_rd    = search ? rho_mask_rd : z_mask_rd;
  assign mask_waddr = {in_data.slot, in_data.residue};
  assign mask_raddr = {ord_rd, mres.idx};
  assign finish     = (state == S_ORD && pos == count) || (state == S_MSK && !mask_rd);

  assign mreq.start = (state == S_START);
  assign mreq.a_abs = a_abs;
  assign mreq.a_neg = a_neg;
  assign mreq.b     = b_val;
  assign mreq.p     = prime_rd;

  msf_ram #(.WIDTH(PRIME_W), .DEPTH(MAX_PRIMES)) u_prime (
    .clk, .we(acc && in_data.command == CMD_PRIME), .waddr(in_data.slot),
    .wdata(in_data.load_value), .raddr(ord_rd), .rdata(prime_rd)
  );

  msf_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_PRIMES)) u_z_ord (
    .clk, .we(acc && in_data.command == CMD_Z_ORDER), .waddr(in_data.slot),
    .wdata(in_data.load_value[SLOT_W-1:0]), .raddr(pos[SLOT_W-1:0]), .rdata(z_ord_rd)
  );

  msf_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_PRIMES)) u_rho_ord (
    .clk, .we(acc && in_data.command == CMD_RHO_ORD), .waddr(in_data.slot),
    .wdata(in_data.load_value[SLOT_W-1:0]), .raddr(pos[SLOT_W-1:0]), .rdata(rho_ord_rd)
  );

  msf_ram #(.WIDTH(1), .DEPTH(MAX_PRIMES * MASK_ENTRIES)) u_z_mask (
    .clk, .we(acc && in_data.command == CMD_Z_MASK), .waddr(mask_waddr),
    .wdata(in_data.load_value[0]), .raddr(mask_raddr), .rdata(z_mask_rd)
  );

  msf_ram #(.WIDTH(1), .DEPTH(MAX_PRIMES * MASK_ENTRIES)) u_rho_mask (
    .clk, .we(acc && in_data.command == CMD_RHO_MASK), .waddr(mask_waddr),
    .wdata(in_data.load_value[0]), .raddr(mask_raddr), .rdata(rho_mask_rd)
  );

  msf_modunit u_mod (
    .clk, .rst, .req(mreq), .res(mres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      pos       <= '0;
      search    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        count <= (cfg_data > COUNT_W'(MAX_PRIMES)) ? COUNT_W'(MAX_PRIMES) : cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc && in_data.command == CMD_QUERY) begin
            a_neg  <= in_data.numerator[31];
            a_abs  <= in_data.numerator[31] ? 32'(-in_data.numerator) : in_data.numerator;
            b_val  <= in_data.denominator;
            pos    <= '0;
            search <= 1'b0;
            state  <= S_ORD;
          end
        end
        S_ORD: begin
          if (pos != count) begin
            state <= S_PRM;
          end
        end
        S_PRM:   state <= S_START;
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (mres.done) begin
            state <= S_MSK;
          end
        end
        S_MSK: begin
          if (mask_rd) begin
            pos   <= pos + COUNT_W'(1);
            state <= S_ORD;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid             <= 1'b1;
            out_data.z_depth      <= z_depth;
            out_data.z_survives   <= (z_depth == count);
            out_data.rho_depth    <= pos;
            out_data.rho_survives <= (pos == count);
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (finish) begin
        if (!search) begin
          z_depth <= pos;
          search  <= 1'b1;
          pos     <= '0;
          state   <= S_ORD;
        end else begin
          state <= S_DONE;
        end
      end
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_DONE) |-> pos <= count)
    else $error("walk position beyond prime count");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mres.done |-> state == S_WAIT)
    else $error("modular unit finished outside wait");

  a_msk_after_wait: assert property (@(posedge clk) disable iff (rst)
    state == S_MSK |-> $past(state) == S_WAIT)
    else $error("mask check without residue");

  a_start_p_read: assert property (@(posedge clk) disable iff (rst)
    state == S_START |-> $past(state) == S_PRM)
    else $error("modular start without prime read");

endmodule
`default_nettype wire
